>>> rtl/wcac_pkg.sv
// Package for the 5x5 window convolution block: sizes, register codes and word types.
// Used by the front, queue, back and top files; depends on nothing.
package wcac_pkg;

    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int KERNEL_SIZE     = 5;
    localparam int HALF            = KERNEL_SIZE / 2;
    localparam int COEF_BITS       = 12;
    localparam int FRAC_BITS       = 9;
    localparam int PIX_BITS        = 8;
    localparam int PIX_MAX         = 255;
    localparam int COEF_ROW_BITS   = KERNEL_SIZE * COEF_BITS;
    localparam int WIDTH_BITS      = 11;
    localparam int HEIGHT_BITS     = 12;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int CFG_DATA_BITS   = COEF_ROW_BITS;
    localparam int FRAME_WIDTH_RST  = 1024;
    localparam int FRAME_HEIGHT_RST = 1024;
    localparam int LB_BITS         = (KERNEL_SIZE - 1) * PIX_BITS;
    localparam int QUEUE_DEPTH     = 4;
    localparam int Q_PTR_BITS      = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_BITS      = $clog2(QUEUE_DEPTH + 1);
    localparam int PROD_BITS       = PIX_BITS + 1 + COEF_BITS;
    localparam int ROW_SUM_BITS    = PROD_BITS + $clog2(KERNEL_SIZE);
    localparam int SUM_BITS        = ROW_SUM_BITS + $clog2(KERNEL_SIZE);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_FRAME_WIDTH,
        REG_FRAME_HEIGHT,
        REG_COEF_ROW0,
        REG_COEF_ROW1,
        REG_COEF_ROW2,
        REG_COEF_ROW3,
        REG_COEF_ROW4
    } cfg_reg_t;

    typedef logic [COEF_ROW_BITS-1:0] coef_row_t;
    typedef coef_row_t [KERNEL_SIZE-1:0] coef_set_t;

    typedef struct packed {
        logic [PIX_BITS-1:0] pixel;
        logic                flush;
    } pix_word_t;

    typedef struct packed {
        logic [PIX_BITS-1:0] filtered;
        logic                frame_last;
    } res_word_t;

    typedef struct packed {
        logic [KERNEL_SIZE-1:0][PIX_BITS-1:0] pix;
        logic [KERNEL_SIZE-1:0]               row_ok;
        logic [KERNEL_SIZE-1:0]               col_ok;
        logic                                 emit;
        logic                                 last;
    } col_word_t;

endpackage

>>> rtl/wcac_stream_if.sv
// Valid/ready stream channel carrying one word of a given type.
// Depends on nothing; the word type comes from wcac_pkg at the instance.
interface wcac_stream_if #(parameter type word_t = logic);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/wcac_front.sv
// Front part: accepts pixel words, tracks frame position, keeps the line buffer
// and forms one column word with edge masks per stream step. Depends on wcac_pkg.
module wcac_front #(
    parameter int MAX_WIDTH = wcac_pkg::MAX_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  wcac_pkg::pix_word_t                   in_data,
    output logic                                  in_ready,
    input  logic [wcac_pkg::WIDTH_BITS-1:0]       frame_width,
    input  logic [wcac_pkg::HEIGHT_BITS-1:0]      frame_height,
    input  logic [wcac_pkg::Q_CNT_BITS-1:0]       q_count,
    output logic                                  push,
    output wcac_pkg::col_word_t                   push_word
);
    import wcac_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int FB = WB + 2;
    localparam int MB = ((WB > HEIGHT_BITS) ? WB : HEIGHT_BITS) + 1;
    localparam int QB = Q_CNT_BITS + 1;

    logic [WB-1:0]          w_eff;
    logic [HEIGHT_BITS-1:0] h_eff;
    logic [FB-1:0]          delay;

    logic [CW-1:0]          scol_reg, scol_next;
    logic [HEIGHT_BITS-1:0] in_row_reg, in_row_next;
    logic [FB-1:0]          fill_reg, fill_next;
    logic [HEIGHT_BITS-1:0] oi_reg, oi_next;
    logic [CW-1:0]          oj_reg, oj_next;

    logic in_input, accept, stream, col_end, oj_end, emit, last;
    logic [PIX_BITS-1:0]    pix_val;
    logic [KERNEL_SIZE-1:0] row_ok, col_ok;
    logic [MB-1:0]          oj_off, oi_off;

    logic                   f1_valid_reg;
    logic [CW-1:0]          f1_col_reg;
    logic [PIX_BITS-1:0]    f1_pix_reg;
    logic [KERNEL_SIZE-1:0] f1_row_ok_reg, f1_col_ok_reg;
    logic                   f1_emit_reg, f1_last_reg;
    logic                   f1_fwd_reg;
    logic [LB_BITS-1:0]     f1_fwd_data_reg;
    logic [LB_BITS-1:0]     rd_data_reg;
    logic [LB_BITS-1:0]     old_rows, wr_data;

    logic [LB_BITS-1:0]     line_mem [MAX_WIDTH];

    always_comb
    begin
        if (frame_width == '0)
        begin
            w_eff = WB'(1);
        end
        else if (32'(frame_width) > MAX_WIDTH)
        begin
            w_eff = WB'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WB'(frame_width);
        end
        h_eff = (frame_height == '0) ? HEIGHT_BITS'(1) : frame_height;
        delay = FB'(HALF) * (FB'(w_eff) + FB'(1));
    end

    assign in_ready = (QB'(q_count) + QB'(f1_valid_reg)) < QB'(QUEUE_DEPTH);
    assign accept   = in_valid && in_ready;
    assign in_input = in_row_reg < h_eff;
    assign stream   = accept && !(in_data.flush && in_input);
    assign pix_val  = in_input ? in_data.pixel : '0;
    assign col_end  = WB'(scol_reg) == (w_eff - WB'(1));
    assign oj_end   = WB'(oj_reg) == (w_eff - WB'(1));
    assign emit     = fill_reg == delay;
    assign last     = emit && oj_end && (oi_reg == (h_eff - HEIGHT_BITS'(1)));

    always_comb
    begin
        scol_next   = scol_reg;
        in_row_next = in_row_reg;
        fill_next   = fill_reg;
        oi_next     = oi_reg;
        oj_next     = oj_reg;
        if (stream)
        begin
            if (last)
            begin
                scol_next   = '0;
                in_row_next = '0;
                fill_next   = '0;
                oi_next     = '0;
                oj_next     = '0;
            end
            else
            begin
                scol_next = col_end ? '0 : scol_reg + CW'(1);
                if (in_input && col_end)
                begin
                    in_row_next = in_row_reg + HEIGHT_BITS'(1);
                end
                if (!emit)
                begin
                    fill_next = fill_reg + FB'(1);
                end
                else if (oj_end)
                begin
                    oj_next = '0;
                    oi_next = oi_reg + HEIGHT_BITS'(1);
                end
                else
                begin
                    oj_next = oj_reg + CW'(1);
                end
            end
        end
    end

    always_comb
    begin
        oj_off = '0;
        oi_off = '0;
        for (int k = 0; k < KERNEL_SIZE; k++)
        begin
            oj_off    = MB'(oj_reg) + MB'(k);
            oi_off    = MB'(oi_reg) + MB'(k);
            col_ok[k] = (oj_off >= MB'(HALF)) && (oj_off < (MB'(w_eff) + MB'(HALF)));
            row_ok[k] = (oi_off >= MB'(HALF)) && (oi_off < (MB'(h_eff) + MB'(HALF)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scol_reg     <= '0;
            in_row_reg   <= '0;
            fill_reg     <= '0;
            oi_reg       <= '0;
            oj_reg       <= '0;
            f1_valid_reg <= 1'b0;
        end
        else
        begin
            scol_reg     <= scol_next;
            in_row_reg   <= in_row_next;
            fill_reg     <= fill_next;
            oi_reg       <= oi_next;
            oj_reg       <= oj_next;
            f1_valid_reg <= stream;
        end
    end

    // A write to the same column in the read cycle is forwarded, which happens at width one.
    assign old_rows = f1_fwd_reg ? f1_fwd_data_reg : rd_data_reg;
    assign wr_data  = {f1_pix_reg, old_rows[LB_BITS-1:PIX_BITS]};

    always_ff @(posedge clk)
    begin
        if (stream)
        begin
            rd_data_reg     <= line_mem[scol_reg];
            f1_fwd_reg      <= f1_valid_reg && (f1_col_reg == scol_reg);
            f1_fwd_data_reg <= wr_data;
            f1_col_reg      <= scol_reg;
            f1_pix_reg      <= pix_val;
            f1_row_ok_reg   <= row_ok;
            f1_col_ok_reg   <= col_ok;
            f1_emit_reg     <= emit;
            f1_last_reg     <= last;
        end
        if (f1_valid_reg)
        begin
            line_mem[f1_col_reg] <= wr_data;
        end
    end

    assign push             = f1_valid_reg;
    assign push_word.pix    = {f1_pix_reg, old_rows};
    assign push_word.row_ok = f1_row_ok_reg;
    assign push_word.col_ok = f1_col_ok_reg;
    assign push_word.emit   = f1_emit_reg;
    assign push_word.last   = f1_last_reg;

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        f1_valid_reg |-> (q_count < Q_CNT_BITS'(QUEUE_DEPTH)))
        else $error("column word pushed into a full queue");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        f1_valid_reg && f1_last_reg |-> (fill_reg == '0) && (oi_reg == '0) && (oj_reg == '0))
        else $error("frame counters not cleared after the last output");

    a_stream_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        stream |=> f1_valid_reg)
        else $error("accepted stream word did not reach the queue stage");

endmodule

>>> rtl/wcac_queue.sv
// Short queue of column words between the front and back parts.
// Depends on wcac_pkg.
module wcac_queue (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  wcac_pkg::col_word_t             push_word,
    input  logic                            pop,
    output logic                            head_valid,
    output wcac_pkg::col_word_t             head_word,
    output logic [wcac_pkg::Q_CNT_BITS-1:0] count
);
    import wcac_pkg::*;

    col_word_t               q_mem [QUEUE_DEPTH];
    logic [Q_PTR_BITS-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_BITS-1:0]   count_reg;

    assign head_valid = count_reg != '0;
    assign head_word  = q_mem[rd_ptr_reg];
    assign count      = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_BITS'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_BITS'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + Q_CNT_BITS'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - Q_CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_word;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < Q_CNT_BITS'(QUEUE_DEPTH)) || pop)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue underflow");

endmodule

>>> rtl/wcac_back.sv
// Back part: 5x5 pixel window, masked products, registered adder tree,
// absolute value with clamp and the result register. Depends on wcac_pkg.
module wcac_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  wcac_pkg::col_word_t   q_word,
    output logic                  pop,
    input  wcac_pkg::coef_set_t   coef,
    output logic                  out_valid,
    input  logic                  out_ready,
    output wcac_pkg::res_word_t   out_data
);
    import wcac_pkg::*;

    logic en;

    logic [PIX_BITS-1:0]    win_reg [KERNEL_SIZE][KERNEL_SIZE];
    logic [KERNEL_SIZE-1:0] win_row_ok_reg, win_col_ok_reg;
    logic                   win_last_reg, w_valid_reg;

    logic signed [PROD_BITS-1:0] prod_next [KERNEL_SIZE][KERNEL_SIZE];
    logic signed [PROD_BITS-1:0] prod_reg  [KERNEL_SIZE][KERNEL_SIZE];
    logic                        p_last_reg, p_valid_reg;

    logic signed [ROW_SUM_BITS-1:0] row_next [KERNEL_SIZE];
    logic signed [ROW_SUM_BITS-1:0] row_reg  [KERNEL_SIZE];
    logic                           r_last_reg, r_valid_reg;

    logic signed [SUM_BITS-1:0] total;
    logic [SUM_BITS-1:0]        mag;
    logic [PIX_BITS-1:0]        clamped;

    logic                out_valid_reg;
    res_word_t           out_data_reg;

    assign en  = !out_valid_reg || out_ready;
    assign pop = en && q_valid;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            for (int dr = 0; dr < KERNEL_SIZE; dr++)
            begin
                for (int dc = 0; dc < KERNEL_SIZE - 1; dc++)
                begin
                    win_reg[dr][dc] <= win_reg[dr][dc+1];
                end
                win_reg[dr][KERNEL_SIZE-1] <= q_word.pix[dr];
            end
            win_row_ok_reg <= q_word.row_ok;
            win_col_ok_reg <= q_word.col_ok;
            win_last_reg   <= q_word.last;
        end
    end

    // Window row dr, column dc meets kernel row and column counted from the far end.
    always_comb
    begin
        logic [PIX_BITS-1:0]         mpix;
        logic signed [COEF_BITS-1:0] cf;
        for (int dr = 0; dr < KERNEL_SIZE; dr++)
        begin
            for (int dc = 0; dc < KERNEL_SIZE; dc++)
            begin
                mpix = (win_row_ok_reg[dr] && win_col_ok_reg[dc]) ? win_reg[dr][dc] : '0;
                cf   = $signed(coef[KERNEL_SIZE-1-dr][(KERNEL_SIZE-1-dc)*COEF_BITS +: COEF_BITS]);
                prod_next[dr][dc] = PROD_BITS'($signed({1'b0, mpix}) * cf);
            end
        end
    end

    always_comb
    begin
        for (int dr = 0; dr < KERNEL_SIZE; dr++)
        begin
            row_next[dr] = '0;
            for (int dc = 0; dc < KERNEL_SIZE; dc++)
            begin
                row_next[dr] = row_next[dr] + ROW_SUM_BITS'(prod_reg[dr][dc]);
            end
        end
    end

    always_comb
    begin
        total = '0;
        for (int dr = 0; dr < KERNEL_SIZE; dr++)
        begin
            total = total + SUM_BITS'(row_reg[dr]);
        end
        mag = total[SUM_BITS-1] ? SUM_BITS'(-total) : SUM_BITS'(total);
        if (mag[SUM_BITS-1:FRAC_BITS+PIX_BITS] != '0)
        begin
            clamped = PIX_BITS'(PIX_MAX);
        end
        else
        begin
            clamped = mag[FRAC_BITS+PIX_BITS-1:FRAC_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg                <= prod_next;
            p_last_reg              <= win_last_reg;
            row_reg                 <= row_next;
            r_last_reg              <= p_last_reg;
            out_data_reg.filtered   <= clamped;
            out_data_reg.frame_last <= r_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_valid_reg   <= 1'b0;
            p_valid_reg   <= 1'b0;
            r_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            w_valid_reg   <= q_valid && q_word.emit;
            p_valid_reg   <= w_valid_reg;
            r_valid_reg   <= p_valid_reg;
            out_valid_reg <= r_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> rtl/window_convolution_abs_clamp.sv
// Streaming 5x5 zero-padded convolution with absolute value and clamp to 255.
// Throughput: one word per cycle in and out while the queue has room and results are taken;
// the line buffer has one read and one write port. Output pixel k leaves with stream word
// k + 2*(width+1) via line buffer stage, queue, window, products, row sums, result register.
// Reset clears counters, queue and pipeline and loads width and height 1024, zero kernel;
// the line buffer is not cleared and needs no clearing pass.
module window_convolution_abs_clamp #(
    parameter int MAX_WIDTH = wcac_pkg::MAX_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    wcac_stream_if.sink                         pixels,
    wcac_stream_if.source                       results,
    input  logic                                cfg_wr_en,
    input  logic [wcac_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [wcac_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import wcac_pkg::*;

    logic [WIDTH_BITS-1:0]  frame_width_reg;
    logic [HEIGHT_BITS-1:0] frame_height_reg;
    coef_set_t              coef_reg;

    logic                  push, pop, head_valid;
    col_word_t             push_word, head_word;
    logic [Q_CNT_BITS-1:0] q_count;
    logic                  out_valid;
    res_word_t             out_data;
    logic                  in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= WIDTH_BITS'(FRAME_WIDTH_RST);
            frame_height_reg <= HEIGHT_BITS'(FRAME_HEIGHT_RST);
            coef_reg         <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[WIDTH_BITS-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[HEIGHT_BITS-1:0];
                REG_COEF_ROW0:    coef_reg[0]      <= cfg_data;
                REG_COEF_ROW1:    coef_reg[1]      <= cfg_data;
                REG_COEF_ROW2:    coef_reg[2]      <= cfg_data;
                REG_COEF_ROW3:    coef_reg[3]      <= cfg_data;
                REG_COEF_ROW4:    coef_reg[4]      <= cfg_data;
                default:          ;
            endcase
        end
    end

    wcac_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (pixels.valid),
        .in_data      (pixels.data),
        .in_ready     (in_ready),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .q_count      (q_count),
        .push         (push),
        .push_word    (push_word)
    );

    wcac_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_word  (push_word),
        .pop        (pop),
        .head_valid (head_valid),
        .head_word  (head_word),
        .count      (q_count)
    );

    wcac_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (head_valid),
        .q_word    (head_word),
        .pop       (pop),
        .coef      (coef_reg),
        .out_valid (out_valid),
        .out_ready (results.ready),
        .out_data  (out_data)
    );

    assign pixels.ready  = in_ready;
    assign results.valid = out_valid;
    assign results.data  = out_data;

endmodule
